// ===== src/u8dec_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 validating decoder.
// No dependencies; imported by every module of the decoder.

package u8dec_pkg;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0]  REG_REPLACEMENT_CODE = 1'b0;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CNT_W = 3;

  localparam logic [CP_W-1:0] REPLACEMENT_RESET = 21'h00FFFD;

  // Byte boundaries of the strict well-formed ranges
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD3_SURR = 8'hED;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] E0_SEC_LO  = 8'hA0;
  localparam logic [7:0] ED_SEC_HI  = 8'h9F;
  localparam logic [7:0] F0_SEC_LO  = 8'h90;
  localparam logic [7:0] F4_SEC_HI  = 8'h8F;

  localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
  localparam logic [CNT_W-1:0] LEN_1    = 3'd1;
  localparam logic [CNT_W-1:0] LEN_2    = 3'd2;
  localparam logic [CNT_W-1:0] LEN_3    = 3'd3;
  localparam logic [CNT_W-1:0] LEN_4    = 3'd4;

  // Open-sequence state carried from byte to byte
  typedef struct packed {
    logic [7:0]       lead;
    logic [23:0]      gathered;
    logic [CNT_W-1:0] exp_len;
    logic [CNT_W-1:0] rcv_cnt;
  } seq_state_t;

  localparam seq_state_t SEQ_CLOSED = '0;

  // One decoded result
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             valid_res;
    logic [CNT_W-1:0] byte_count;
  } dec_result_t;

  // Sequence length announced by a lead byte; stray bytes count as one
  function automatic logic [CNT_W-1:0] lead_length(input logic [7:0] b);
    logic [CNT_W-1:0] len;
    if (b[7] == 1'b0) len = LEN_1;
    else if (b[7:5] == 3'b110) len = LEN_2;
    else if (b[7:4] == 4'b1110) len = LEN_3;
    else if (b[7:3] == 5'b11110) len = LEN_4;
    else len = LEN_1;
    return len;
  endfunction

  function automatic logic in_range(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

// ===== src/u8dec_step.sv =====
// Per-byte decode step: next sequence state and the result a byte causes.
// Purely combinational; depends on u8dec_pkg.

module u8dec_step (
  input  logic [7:0]                     data_byte,
  input  logic                           end_of_range,
  input  logic [u8dec_pkg::CP_W-1:0]     replacement_code,
  input  u8dec_pkg::seq_state_t          st,
  output u8dec_pkg::seq_state_t          st_nxt,
  output logic                           res_valid,
  output u8dec_pkg::dec_result_t         res
);
  import u8dec_pkg::*;

  logic [CNT_W-1:0] len;
  logic [23:0]      gath;
  logic [CNT_W-1:0] rcv;
  logic [7:0]       b1, b2, b3, b4;
  logic [7:0]       lo2, hi2;
  logic             seq_ok;
  logic [CP_W-1:0]  seq_cp;

  assign len  = lead_length(data_byte);
  assign gath = {st.gathered[15:0], data_byte};
  assign rcv  = st.rcv_cnt + LEN_1;
  assign b1   = st.lead;

  // Judge a complete multi-byte sequence against the strict ranges
  always_comb begin
    b2 = 8'h00;
    b3 = 8'h00;
    b4 = 8'h00;
    lo2 = CONT_LO;
    hi2 = CONT_HI;
    seq_ok = 1'b0;
    seq_cp = '0;
    case (st.exp_len)
      LEN_2: begin
        b2 = gath[7:0];
        seq_ok = in_range(b1, LEAD2_LO, LEAD2_HI) && in_range(b2, CONT_LO, CONT_HI);
        seq_cp = {10'd0, b1[4:0], b2[5:0]};
      end
      LEN_3: begin
        b2 = gath[15:8];
        b3 = gath[7:0];
        if (b1 == LEAD3_LO) lo2 = E0_SEC_LO;
        if (b1 == LEAD3_SURR) hi2 = ED_SEC_HI;
        seq_ok = in_range(b1, LEAD3_LO, LEAD3_HI) && in_range(b2, lo2, hi2) &&
                 in_range(b3, CONT_LO, CONT_HI);
        seq_cp = {5'd0, b1[3:0], b2[5:0], b3[5:0]};
      end
      default: begin
        b2 = gath[23:16];
        b3 = gath[15:8];
        b4 = gath[7:0];
        if (b1 == LEAD4_LO) lo2 = F0_SEC_LO;
        if (b1 == LEAD4_HI) hi2 = F4_SEC_HI;
        seq_ok = in_range(b1, LEAD4_LO, LEAD4_HI) && in_range(b2, lo2, hi2) &&
                 in_range(b3, CONT_LO, CONT_HI) && in_range(b4, CONT_LO, CONT_HI);
        seq_cp = {b1[2:0], b2[5:0], b3[5:0], b4[5:0]};
      end
    endcase
  end

  // Advance the open sequence and pick the result
  always_comb begin
    st_nxt = st;
    res_valid = 1'b0;
    res.code_point = replacement_code;
    res.valid_res = 1'b0;
    res.byte_count = LEN_1;
    if (st.exp_len == LEN_NONE) begin
      if (len == LEN_1) begin
        // single byte: ASCII passes, a stray byte is replaced
        res_valid = 1'b1;
        res.valid_res = ~data_byte[7];
        res.code_point = data_byte[7] ? replacement_code : {13'd0, data_byte};
      end else if (end_of_range) begin
        // lead byte cut off by the buffer end
        res_valid = 1'b1;
        st_nxt = SEQ_CLOSED;
      end else begin
        st_nxt.lead = data_byte;
        st_nxt.gathered = '0;
        st_nxt.exp_len = len;
        st_nxt.rcv_cnt = LEN_1;
      end
    end else if (rcv >= st.exp_len) begin
      res_valid = 1'b1;
      res.valid_res = seq_ok;
      res.code_point = seq_ok ? seq_cp : replacement_code;
      res.byte_count = st.exp_len;
      st_nxt = SEQ_CLOSED;
    end else if (end_of_range) begin
      res_valid = 1'b1;
      res.byte_count = rcv;
      st_nxt = SEQ_CLOSED;
    end else begin
      st_nxt.gathered = gath;
      st_nxt.rcv_cnt = rcv;
    end
  end

endmodule

// ===== src/utf8_validating_decoder.sv =====
// Top level of the UTF-8 validating decoder: handshakes, config register,
// sequence state and a two-entry result buffer. Depends on u8dec_pkg, u8dec_step.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------
//   in      | sink      | in_valid / in_stall   | in_data_byte, in_end_of_range
//   out     | source    | out_valid / out_stall | out_code_point, out_valid_res,
//           |           |                       | out_byte_count
//   cfg     | APB slave | psel/penable/pready   | paddr, pwdata, prdata
//
// One byte is taken per cycle while in_stall is low; each result is registered.
// The rate is set by the single decode step between the sequence state register
// and the result register. A skid entry behind the output register keeps input
// flowing for one more result while the output is stalled; in_stall rises only
// once both entries are full. Synchronous reset closes any open sequence,
// empties the result buffer and restores the replacement code to U+FFFD.

module utf8_validating_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_end_of_range,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [u8dec_pkg::CP_W-1:0]       out_code_point,
  output logic                             out_valid_res,
  output logic [u8dec_pkg::CNT_W-1:0]      out_byte_count,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [u8dec_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [u8dec_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [u8dec_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import u8dec_pkg::*;

  logic [CP_W-1:0] repl_r;
  seq_state_t      st_r, st_nxt;
  logic            res_valid;
  dec_result_t     res;
  logic            in_xfer, out_xfer;
  logic            out_valid_r, out_valid_nxt;
  dec_result_t     out_r, out_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  dec_result_t     skid_r, skid_nxt;
  logic            reg_sel;

  // Config port: always ready, one register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_REPLACEMENT_CODE);
  assign prdata  = reg_sel ? {{(CFG_DATA_W-CP_W){1'b0}}, repl_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= REPLACEMENT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      repl_r <= pwdata[CP_W-1:0];
    end
  end

  // Decode step
  u8dec_step u_step (
    .data_byte        (in_data_byte),
    .end_of_range     (in_end_of_range),
    .replacement_code (repl_r),
    .st               (st_r),
    .st_nxt           (st_nxt),
    .res_valid        (res_valid),
    .res              (res)
  );

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // Hold sequence state; advance on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SEQ_CLOSED;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // Output register plus skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_xfer) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_xfer || !out_valid_r) begin
      out_valid_nxt = in_xfer && res_valid;
      out_nxt       = res;
    end else if (in_xfer && res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_r.code_point;
  assign out_valid_res  = out_r.valid_res;
  assign out_byte_count = out_r.byte_count;

endmodule

// ===== src/utf8_validating_decoder_chk.sv =====
// Port-level checker for the UTF-8 validating decoder, bound to the top level.
// Depends on u8dec_pkg.

module utf8_validating_decoder_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [u8dec_pkg::CP_W-1:0]   out_code_point,
  input logic                         out_valid_res,
  input logic [u8dec_pkg::CNT_W-1:0]  out_byte_count
);
  import u8dec_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its code point
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_code_point))
    else $error("code point changed while stalled");

  // A valid result's byte count lies between one and four
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count != 3'd0) && (out_byte_count <= LEN_4))
    else $error("byte count out of range");

  // A good code point is a scalar value: no surrogate, nothing past U+10FFFF
  a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |->
      (out_code_point <= 21'h10FFFF) &&
      ((out_code_point < 21'h00D800) || (out_code_point > 21'h00DFFF)))
    else $error("well-formed result is not a scalar value");

  // A good code point matches its encoded length (no overlongs)
  a_shortest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |->
      ((out_byte_count == LEN_1) && (out_code_point < 21'h000080)) ||
      ((out_byte_count == LEN_2) && (out_code_point >= 21'h000080) &&
       (out_code_point < 21'h000800)) ||
      ((out_byte_count == LEN_3) && (out_code_point >= 21'h000800) &&
       (out_code_point < 21'h010000)) ||
      ((out_byte_count == LEN_4) && (out_code_point >= 21'h010000)))
    else $error("well-formed result is not shortest form");

endmodule

bind utf8_validating_decoder utf8_validating_decoder_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_code_point (out_code_point),
  .out_valid_res  (out_valid_res),
  .out_byte_count (out_byte_count)
);

// ===== tb/utf8_validating_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_validating_decoder: directed and random byte
// streams, predicted results compared field by field. Depends on u8dec_pkg.

module utf8_validating_decoder_tb;

  import u8dec_pkg::CP_W;
  import u8dec_pkg::CNT_W;
  import u8dec_pkg::CFG_ADDR_W;
  import u8dec_pkg::CFG_DATA_W;
  import u8dec_pkg::REG_REPLACEMENT_CODE;
  import u8dec_pkg::dec_result_t;

  localparam logic [CFG_ADDR_W-1:0] REPL_ADDR = CFG_ADDR_W'(4 * REG_REPLACEMENT_CODE);
  localparam logic [CP_W-1:0]       REPL_AT_RESET = 21'h00FFFD;
  localparam logic [CP_W-1:0]       MAX_SCALAR = 21'h10FFFF;
  localparam logic [2:0]            NO_SEQ = 3'd0;
  localparam int                    NO_FLAG = 4;
  localparam int                    CYCLE_LIMIT = 200000;
  localparam int                    REPORT_LIMIT = 10;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_data_byte;
  logic                  in_end_of_range;
  logic                  out_valid;
  logic                  out_stall;
  logic [CP_W-1:0]       out_code_point;
  logic                  out_valid_res;
  logic [CNT_W-1:0]      out_byte_count;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  utf8_validating_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_range (in_end_of_range),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_valid_res   (out_valid_res),
    .out_byte_count  (out_byte_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Predicted decoder state and replacement setting
  logic [7:0]      seq_lead;
  logic [23:0]     seq_tail;
  logic [2:0]      seq_len;
  logic [2:0]      seq_got;
  logic [CP_W-1:0] repl_code;

  dec_result_t pending_decodes[$];
  dec_result_t want;
  int          mismatches;
  int          items_sent;
  int          cycle_count;
  logic        idle_on;

  // Clock: 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Random back-pressure on the result side
  always @(negedge clk) begin
    out_stall = rst_n && idle_on && ($urandom_range(99) < 8);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    mismatches = mismatches + 1;
    if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", what);
  endtask

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_decodes.size() == 0) begin
        note_mismatch($sformatf("unexpected result cp=%h valid=%b count=%0d",
                                out_code_point, out_valid_res, out_byte_count));
      end else begin
        want = pending_decodes.pop_front();
        if (out_code_point !== want.code_point || out_valid_res !== want.valid_res ||
            out_byte_count !== want.byte_count) begin
          note_mismatch($sformatf("expected cp=%h valid=%b count=%0d, got cp=%h valid=%b count=%0d",
                                  want.code_point, want.valid_res, want.byte_count,
                                  out_code_point, out_valid_res, out_byte_count));
        end
      end
    end
  end

  // Sequence length announced by a lead byte; stray bytes stand alone
  function automatic logic [2:0] announced_len(input logic [7:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd1;
    endcase
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // Strict well-formedness of a complete multi-byte sequence
  function automatic logic well_formed(input logic [2:0] len, input logic [7:0] b1,
                                       input logic [23:0] tail,
                                       output logic [CP_W-1:0] cp);
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       ok;
    lo = 8'h80;
    hi = 8'hBF;
    case (len)
      3'd2: begin
        b2 = tail[7:0];
        ok = b1 >= 8'hC2 && b1 <= 8'hDF && is_cont(b2);
        cp = {10'b0, b1[4:0], b2[5:0]};
      end
      3'd3: begin
        b2 = tail[15:8];
        b3 = tail[7:0];
        if (b1 == 8'hE0) lo = 8'hA0;
        if (b1 == 8'hED) hi = 8'h9F;
        ok = b1 >= 8'hE0 && b1 <= 8'hEF && b2 >= lo && b2 <= hi && is_cont(b3);
        cp = {5'b0, b1[3:0], b2[5:0], b3[5:0]};
      end
      default: begin
        b2 = tail[23:16];
        b3 = tail[15:8];
        b4 = tail[7:0];
        if (b1 == 8'hF0) lo = 8'h90;
        if (b1 == 8'hF4) hi = 8'h8F;
        ok = b1 >= 8'hF0 && b1 <= 8'hF4 && b2 >= lo && b2 <= hi &&
             is_cont(b3) && is_cont(b4);
        cp = {b1[2:0], b2[5:0], b3[5:0], b4[5:0]};
      end
    endcase
    return ok;
  endfunction

  function automatic void push_decode(input logic ok, input logic [CP_W-1:0] cp,
                                      input logic [2:0] count);
    dec_result_t r;
    r.code_point = ok ? cp : repl_code;
    r.valid_res  = ok;
    r.byte_count = count;
    pending_decodes.push_back(r);
  endfunction

  function automatic void close_seq();
    seq_lead = 8'h00;
    seq_tail = 24'h0;
    seq_len  = NO_SEQ;
    seq_got  = 3'd0;
  endfunction

  // Advance the predicted state by one accepted byte
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [CP_W-1:0] cp;
    logic            ok;
    if (seq_len == NO_SEQ) begin
      if (announced_len(b) == 3'd1) begin
        push_decode(!b[7], {13'b0, b}, 3'd1);
      end else if (last) begin
        push_decode(1'b0, '0, 3'd1);
      end else begin
        seq_lead = b;
        seq_tail = 24'h0;
        seq_len  = announced_len(b);
        seq_got  = 3'd1;
      end
    end else begin
      seq_tail = {seq_tail[15:0], b};
      seq_got  = seq_got + 3'd1;
      if (seq_got >= seq_len) begin
        ok = well_formed(seq_len, seq_lead, seq_tail, cp);
        push_decode(ok, cp, seq_len);
        close_seq();
      end else if (last) begin
        push_decode(1'b0, '0, seq_got);
        close_seq();
      end
    end
  endfunction

  // Send one byte; called and returns at a falling edge, leaves valid high
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_on && $urandom_range(99) < 8) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_data_byte    = b;
    in_end_of_range = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, last);
    items_sent = items_sent + 1;
    @(negedge clk);
  endtask

  // Send up to n bytes, left-aligned in seq; the end flag stops the transfer
  task automatic send_seq(input logic [31:0] seq, input int n, input int flag_at);
    for (int i = 0; i < n; i++) begin
      send_byte(seq[31-8*i -: 8], i == flag_at);
      if (i == flag_at) break;
    end
  endtask

  // Hold input until every predicted result has been transferred
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_replacement();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = REPL_ADDR;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CP_W-1:0] !== repl_code)
      note_mismatch($sformatf("replacement readback expected %h, got %h",
                              repl_code, prdata[CP_W-1:0]));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Close any open sequence, drain, then write and read back the setting
  task automatic set_replacement(input logic [CP_W-1:0] value);
    send_byte(8'h41, 1'b1);
    drain_results();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REPL_ADDR;
    pwdata  = {{(CFG_DATA_W-CP_W){1'b0}}, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    repl_code = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    check_replacement();
  endtask

  function automatic logic [CP_W-1:0] random_scalar();
    logic [CP_W-1:0] cp;
    case ($urandom_range(3))
      0: cp = CP_W'($urandom_range(32'h7F));
      1: cp = CP_W'($urandom_range(32'h7FF, 32'h80));
      2: begin
        cp = CP_W'($urandom_range(32'hFFFF, 32'h800));
        // fold surrogates down into the plain BMP range
        if (cp[15:11] == 5'b11011) cp[12] = 1'b0;
      end
      default: cp = CP_W'($urandom_range(32'h10FFFF, 32'h10000));
    endcase
    return cp;
  endfunction

  function automatic int utf8_len(input logic [CP_W-1:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  function automatic logic [31:0] utf8_bytes(input logic [CP_W-1:0] cp);
    case (utf8_len(cp))
      1: return {cp[7:0], 24'h0};
      2: return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
      3: return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
      default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                       2'b10, cp[5:0]};
    endcase
  endfunction

  // Mostly well-formed sequences, plus broken ones and raw noise bytes
  task automatic send_random_traffic(input int count);
    int              stop_at;
    int              pick;
    int              n;
    int              flag_at;
    int              idx;
    logic [CP_W-1:0] cp;
    logic [31:0]     seq;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick    = $urandom_range(99);
      cp      = random_scalar();
      n       = utf8_len(cp);
      seq     = utf8_bytes(cp);
      flag_at = ($urandom_range(9) == 0) ? n - 1 : NO_FLAG;
      if (pick < 65) begin
        send_seq(seq, n, flag_at);
      end else if (pick < 85 && n > 1) begin
        case ($urandom_range(2))
          0: begin
            idx = $urandom_range(n - 1, 1);
            seq[31-8*idx -: 8] = 8'($urandom_range(255));
          end
          1: begin
            // keep the lead's length class, scramble its payload bits
            if (n == 2) seq[28:24] = 5'($urandom_range(31));
            else if (n == 3) seq[27:24] = 4'($urandom_range(15));
            else seq[26:24] = 3'($urandom_range(7));
          end
          default: flag_at = $urandom_range(n - 2);
        endcase
        send_seq(seq, n, flag_at);
      end else begin
        send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
      end
    end
  endtask

  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_two_byte();
    send_seq(32'hDFBF_0000, 2, NO_FLAG);
    send_seq(32'hC180_0000, 2, NO_FLAG);
  endtask

  task automatic test_three_byte();
    send_seq(32'hE09F_BF00, 3, NO_FLAG);
    send_seq(32'hEDA0_8000, 3, NO_FLAG);
  endtask

  task automatic test_four_byte();
    send_seq(32'hF48F_BFBF, 4, 3);
    send_seq(32'hF580_8080, 4, NO_FLAG);
  endtask

  task automatic test_bad_continuation();
    send_seq(32'hC341_0000, 2, NO_FLAG);
  endtask

  task automatic test_truncation();
    send_seq(32'hE282_0000, 2, 1);
    send_byte(8'hF0, 1'b1);
  endtask

  task automatic test_replacement_extremes();
    set_replacement(21'h0);
    send_seq(32'hC080_0000, 2, NO_FLAG);
    set_replacement(MAX_SCALAR);
    send_seq(32'hF090_8080, 4, NO_FLAG);
    send_byte(8'hBF, 1'b0);
  endtask

  // Pause the sender mid-stream until every result is out
  task automatic test_drain_pause();
    send_random_traffic(60);
    send_byte(8'h41, 1'b1);
    drain_results();
    send_random_traffic(60);
  endtask

  task automatic test_no_idling();
    set_replacement(21'h0);
    idle_on = 1'b0;
    send_random_traffic(500);
    idle_on = 1'b1;
  endtask

  task automatic test_random_setting();
    set_replacement(CP_W'($urandom_range(32'h10FFFF)));
    send_random_traffic(600);
    set_replacement(REPL_AT_RESET);
    send_random_traffic(100);
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_byte    = 8'h00;
    in_end_of_range = 1'b0;
    out_stall       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatches      = 0;
    items_sent      = 0;
    cycle_count     = 0;
    idle_on         = 1'b1;
    repl_code       = REPL_AT_RESET;
    close_seq();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    check_replacement();
    test_single_bytes();
    test_two_byte();
    test_three_byte();
    test_four_byte();
    test_bad_continuation();
    test_truncation();
    test_replacement_extremes();
    send_random_traffic(600);
    test_drain_pause();
    test_no_idling();
    test_random_setting();

    // Let the last results out
    in_valid = 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
